// File: rtl/isotp_pkg.sv
// Shared types and constants for the ISO-TP receive reassembler.
// No dependencies; imported by isotp_decode, isotp_receive_reassembler and the testbench.
package isotp_pkg;

    localparam int BUFFER_BYTES_DEF = 64;
    localparam int LEN_W            = 7;
    localparam int SEQ_W            = 4;
    localparam int CNT_W            = 3;

    localparam logic [3:0] TYPE_SF = 4'h0;
    localparam logic [3:0] TYPE_FF = 4'h1;
    localparam logic [3:0] TYPE_CF = 4'h2;

    localparam logic [3:0]       DLC_MAX    = 4'd8;
    localparam logic [LEN_W-1:0] SF_MAX     = 7'd7;
    localparam logic [LEN_W-1:0] CF_MAX     = 7'd7;
    localparam logic [LEN_W-1:0] FF_PAYLOAD = 7'd6;
    localparam logic [11:0]      FF_MIN_LEN = 12'd7;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_SF_EMPTY,
        ACT_SF_DATA,
        ACT_FF,
        ACT_CF_BAD_SEQ,
        ACT_CF_DATA
    } act_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_CTS   = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_EMIT,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        act_t             act;
        logic [CNT_W-1:0] count;
        logic [LEN_W-1:0] len;
        logic             complete;
    } decode_t;

endpackage

// File: rtl/isotp_decode.sv
// Frame classifier: decodes one CAN frame against the reassembly state.
// Depends on isotp_pkg.
module isotp_decode
    import isotp_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)
(
    input  logic [3:0]       frame_len,
    input  logic [7:0]       frame_byte0,
    input  logic [7:0]       frame_byte1,
    input  logic             reassembling,
    input  logic [SEQ_W-1:0] next_sequence,
    input  logic [LEN_W-1:0] expected_length,
    input  logic [LEN_W-1:0] bytes_held,
    output decode_t          dec
);

    localparam logic [11:0] BUF_MAX = 12'(BUFFER_BYTES);

    logic [3:0]       dlc;
    logic [LEN_W-1:0] avail;
    logic [LEN_W-1:0] sfl;
    logic [11:0]      len12;
    logic [LEN_W-1:0] rem;
    logic [LEN_W-1:0] n;
    logic [LEN_W:0]   held_sum;

    always_comb
    begin
        dlc      = (frame_len > DLC_MAX) ? DLC_MAX : frame_len;
        avail    = LEN_W'(dlc - 4'd1);
        sfl      = LEN_W'(frame_byte0[3:0]);
        len12    = {frame_byte0[3:0], frame_byte1};
        rem      = expected_length - bytes_held;
        n        = (rem > CF_MAX) ? CF_MAX : rem;
        n        = (n > avail) ? avail : n;
        held_sum = {1'b0, bytes_held} + {1'b0, n};

        dec          = '0;
        dec.act      = ACT_NONE;
        if (dlc != 4'd0)
        begin
            unique case (frame_byte0[7:4])
                TYPE_SF:
                begin
                    if (sfl <= SF_MAX && sfl <= avail)
                    begin
                        dec.act   = (sfl == '0) ? ACT_SF_EMPTY : ACT_SF_DATA;
                        dec.count = sfl[CNT_W-1:0];
                        dec.len   = sfl;
                    end
                end
                TYPE_FF:
                begin
                    if (dlc == DLC_MAX && len12 >= FF_MIN_LEN && len12 <= BUF_MAX)
                    begin
                        dec.act   = ACT_FF;
                        dec.count = FF_PAYLOAD[CNT_W-1:0];
                        dec.len   = len12[LEN_W-1:0];
                    end
                end
                TYPE_CF:
                begin
                    if (reassembling && dlc >= 4'd2)
                    begin
                        if (frame_byte0[3:0] != next_sequence)
                        begin
                            dec.act = ACT_CF_BAD_SEQ;
                        end
                        else
                        begin
                            dec.act      = ACT_CF_DATA;
                            dec.count    = n[CNT_W-1:0];
                            dec.len      = expected_length;
                            dec.complete = (held_sum >= {1'b0, expected_length});
                        end
                    end
                end
                default:
                begin
                    dec.act = ACT_NONE;
                end
            endcase
        end
    end

endmodule

// File: rtl/isotp_receive_reassembler.sv
// ISO-TP receive reassembler top level: frame capture, buffer memory, drain.
// Depends on isotp_pkg and isotp_decode.
//
// Usage:
//   Input channel (frame_valid/frame_ready) takes one CAN frame per beat:
//   frame_len and frame_byte0..7. Output channel (result_valid/result_ready)
//   gives one result per beat: result_kind, payload_byte, message_length,
//   last. Results of one frame come in order with last set on the final one.
//   Single frames stream their bytes straight from the captured frame, one
//   per cycle unless the receiver stalls. First and consecutive frames write
//   their bytes into the assembly buffer, one byte per cycle through its
//   single write port. When a message completes, the buffer is read back
//   one byte per cycle (registered read port, no bubbles while result_ready
//   is high). frame_ready is high only while no frame is being processed;
//   it rises again once the last write is done or, for a frame with
//   results, once the last result sits in the output register.
//   A stalled receiver holds the output register and stops the drain.
//   Reset clears the control state and drops any partial message; buffer
//   contents are not cleared and are never read before being written.
module isotp_receive_reassembler
    import isotp_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       frame_valid,
    output logic       frame_ready,
    input  logic [3:0] frame_len,
    input  logic [7:0] frame_byte0,
    input  logic [7:0] frame_byte1,
    input  logic [7:0] frame_byte2,
    input  logic [7:0] frame_byte3,
    input  logic [7:0] frame_byte4,
    input  logic [7:0] frame_byte5,
    input  logic [7:0] frame_byte6,
    input  logic [7:0] frame_byte7,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [1:0] result_kind,
    output logic [7:0] payload_byte,
    output logic [6:0] message_length,
    output logic       last
);

    localparam int AW = $clog2(BUFFER_BYTES);

    logic [7:0] buf_mem [BUFFER_BYTES];

    state_t           state_reg, state_next;
    logic             reassembling_reg;
    logic [SEQ_W-1:0] next_sequence_reg;
    logic [LEN_W-1:0] expected_length_reg;
    logic [LEN_W-1:0] bytes_held_reg;

    act_t             act_reg;
    logic             complete_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [LEN_W-1:0] len_reg;
    logic [AW-1:0]    wr_base_reg;
    logic [7:0]       data_reg [7];
    kind_t            res_kind_reg;

    logic [LEN_W-1:0] rd_idx_reg;
    logic [LEN_W-1:0] out_idx_reg;
    logic             pend_reg;
    logic [7:0]       rdata_reg;

    logic             out_valid_reg;
    kind_t            out_kind_reg;
    logic [7:0]       out_byte_reg;
    logic [LEN_W-1:0] out_len_reg;
    logic             out_last_reg;

    decode_t          dec;
    logic             accept;
    logic             out_load;
    logic             move;
    logic             rd_en;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic             want;
    kind_t            emit_kind;
    logic [7:0]       emit_byte;
    logic             emit_last;
    logic             idx_end;

    isotp_decode #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_decode (
        .frame_len      (frame_len),
        .frame_byte0    (frame_byte0),
        .frame_byte1    (frame_byte1),
        .reassembling   (reassembling_reg),
        .next_sequence  (next_sequence_reg),
        .expected_length(expected_length_reg),
        .bytes_held     (bytes_held_reg),
        .dec            (dec)
    );

    assign frame_ready = (state_reg == ST_IDLE);
    assign accept      = frame_valid && frame_ready;
    assign out_load    = !out_valid_reg || result_ready;
    assign move        = (state_reg == ST_DRAIN) && pend_reg && out_load;
    assign idx_end     = (idx_reg == cnt_reg - 3'd1);
    assign rd_en       = (state_reg == ST_DRAIN) && (rd_idx_reg < len_reg)
                         && (!pend_reg || move);
    assign wr_addr     = wr_base_reg + AW'(idx_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (dec.act)
                        ACT_SF_EMPTY:            state_next = ST_RESULT;
                        ACT_SF_DATA:             state_next = ST_EMIT;
                        ACT_FF, ACT_CF_DATA:     state_next = ST_WRITE;
                        ACT_NONE, ACT_CF_BAD_SEQ: state_next = ST_IDLE;
                        default:                 state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE:
            begin
                if (idx_end)
                begin
                    priority if (act_reg == ACT_FF)
                        state_next = ST_RESULT;
                    else if (complete_reg)
                        state_next = ST_DRAIN;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_load && idx_end)
                    state_next = ST_IDLE;
            end
            ST_DRAIN:
            begin
                if (move && emit_last)
                    state_next = ST_IDLE;
            end
            ST_RESULT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        want      = 1'b0;
        wr_en     = 1'b0;
        emit_kind = KIND_BYTE;
        emit_byte = '0;
        emit_last = 1'b0;
        unique case (state_reg)
            ST_WRITE:
            begin
                wr_en = 1'b1;
            end
            ST_EMIT:
            begin
                want      = 1'b1;
                emit_byte = data_reg[idx_reg];
                emit_last = idx_end;
            end
            ST_DRAIN:
            begin
                want      = pend_reg;
                emit_byte = rdata_reg;
                emit_last = (out_idx_reg == len_reg - 7'd1);
            end
            ST_RESULT:
            begin
                want      = 1'b1;
                emit_kind = res_kind_reg;
                emit_last = 1'b1;
            end
            default:
            begin
                want = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            reassembling_reg    <= 1'b0;
            next_sequence_reg   <= '0;
            expected_length_reg <= '0;
            bytes_held_reg      <= '0;
            pend_reg            <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                priority case (dec.act)
                    ACT_FF:
                    begin
                        expected_length_reg <= dec.len;
                        bytes_held_reg      <= FF_PAYLOAD;
                        next_sequence_reg   <= 4'd1;
                        reassembling_reg    <= 1'b1;
                    end
                    ACT_CF_BAD_SEQ:
                    begin
                        reassembling_reg <= 1'b0;
                    end
                    ACT_CF_DATA:
                    begin
                        bytes_held_reg    <= bytes_held_reg + LEN_W'(dec.count);
                        next_sequence_reg <= next_sequence_reg + 4'd1;
                        if (dec.complete)
                            reassembling_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (rd_en)
                pend_reg <= 1'b1;
            else if (move)
                pend_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= want;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg      <= dec.act;
            complete_reg <= dec.complete;
            cnt_reg      <= dec.count;
            len_reg      <= dec.len;
            idx_reg      <= '0;
            rd_idx_reg   <= '0;
            out_idx_reg  <= '0;
            res_kind_reg <= (dec.act == ACT_FF) ? KIND_CTS : KIND_EMPTY;
            wr_base_reg  <= (dec.act == ACT_FF) ? '0 : bytes_held_reg[AW-1:0];
            if (dec.act == ACT_FF)
            begin
                data_reg[0] <= frame_byte2;
                data_reg[1] <= frame_byte3;
                data_reg[2] <= frame_byte4;
                data_reg[3] <= frame_byte5;
                data_reg[4] <= frame_byte6;
                data_reg[5] <= frame_byte7;
                data_reg[6] <= 8'd0;
            end
            else
            begin
                data_reg[0] <= frame_byte1;
                data_reg[1] <= frame_byte2;
                data_reg[2] <= frame_byte3;
                data_reg[3] <= frame_byte4;
                data_reg[4] <= frame_byte5;
                data_reg[5] <= frame_byte6;
                data_reg[6] <= frame_byte7;
            end
        end
        else
        begin
            if (wr_en || (state_reg == ST_EMIT && out_load))
                idx_reg <= idx_reg + 3'd1;
            if (rd_en)
                rd_idx_reg <= rd_idx_reg + 7'd1;
            if (move)
                out_idx_reg <= out_idx_reg + 7'd1;
        end
        if (out_load && want)
        begin
            out_kind_reg <= emit_kind;
            out_byte_reg <= emit_byte;
            out_len_reg  <= (emit_kind == KIND_EMPTY) ? '0 : len_reg;
            out_last_reg <= emit_last;
        end
    end

    // assembly buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_mem[wr_addr] <= data_reg[idx_reg];
        if (rd_en)
            rdata_reg <= buf_mem[rd_idx_reg[AW-1:0]];
    end

    assign result_valid   = out_valid_reg;
    assign result_kind    = out_kind_reg;
    assign payload_byte   = out_byte_reg;
    assign message_length = out_len_reg;
    assign last           = out_last_reg;

    a_wr_below_held: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ({1'b0, wr_addr} < {1'b0, bytes_held_reg[AW-1:0]}
                   || bytes_held_reg >= LEN_W'(BUFFER_BYTES)))
        else $error("buffer write at or above bytes held");

    a_rd_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (rd_idx_reg < expected_length_reg))
        else $error("buffer read beyond message length");

    a_held_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        reassembling_reg |-> (bytes_held_reg < expected_length_reg))
        else $error("reassembly armed with complete buffer");

    a_pend_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_DRAIN))
        else $error("read data pending outside drain");

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !frame_ready)
        else $error("frame accepted while busy");

endmodule

// File: dv/tb_isotp_receive_reassembler.sv
`timescale 1ns / 100ps

// Testbench for isotp_receive_reassembler: directed and random CAN frames checked
// against a built-in ISO-TP reassembly predictor, with random stalls on both channels.
// Depends on isotp_pkg and the isotp_receive_reassembler RTL.
module tb_isotp_receive_reassembler;
    import isotp_pkg::*;

    localparam int BUF_BYTES    = BUFFER_BYTES_DEF;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int MAX_WAIT     = 13;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_SLACK  = 80;
    localparam int QUIET_LIMIT  = 3000;
    localparam int RANDOM_ITEMS = 120;
    localparam int MAX_REPORTS  = 40;

    // flow-control frames and anything above are not receive traffic
    localparam logic [3:0] TYPE_FC   = 4'h3;
    localparam logic [3:0] TYPE_LAST = 4'hF;

    typedef struct packed {
        logic [3:0]      dlc;
        logic [7:0][7:0] data;
    } frame_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [6:0] len;
        logic       last;
    } result_t;

    logic       clk;
    logic       rst_n;
    logic       frame_valid;
    logic       frame_ready;
    logic [3:0] frame_len;
    logic [7:0] frame_byte0;
    logic [7:0] frame_byte1;
    logic [7:0] frame_byte2;
    logic [7:0] frame_byte3;
    logic [7:0] frame_byte4;
    logic [7:0] frame_byte5;
    logic [7:0] frame_byte6;
    logic [7:0] frame_byte7;
    logic       result_valid;
    logic       result_ready;
    logic [1:0] result_kind;
    logic [7:0] payload_byte;
    logic [6:0] message_length;
    logic       last;

    result_t    due_results[$];
    logic [7:0] asm_buf [BUF_BYTES];
    int         asm_len    = 0;
    int         asm_held   = 0;
    logic [3:0] asm_seq    = '0;
    bit         asm_active = 1'b0;

    bit sender_pauses   = 1'b1;
    bit receiver_pauses = 1'b1;
    int receiver_hold   = 0;

    int mismatch_count       = 0;
    int frames_sent          = 0;
    int frames_effective     = 0;
    int results_checked      = 0;
    int messages_reassembled = 0;
    int singles_delivered    = 0;
    int quiet_cycles         = 0;

    isotp_receive_reassembler #(.BUFFER_BYTES(BUF_BYTES)) u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_valid    (frame_valid),
        .frame_ready    (frame_ready),
        .frame_len      (frame_len),
        .frame_byte0    (frame_byte0),
        .frame_byte1    (frame_byte1),
        .frame_byte2    (frame_byte2),
        .frame_byte3    (frame_byte3),
        .frame_byte4    (frame_byte4),
        .frame_byte5    (frame_byte5),
        .frame_byte6    (frame_byte6),
        .frame_byte7    (frame_byte7),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result_kind    (result_kind),
        .payload_byte   (payload_byte),
        .message_length (message_length),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic int draw_wait(input bit pauses);
        return pauses ? $urandom_range(0, MAX_WAIT) : 0;
    endfunction

    function automatic frame_t make_frame(input int dlc, input logic [7:0] pci);
        frame_t f;
        int     i;
        f.dlc     = dlc[3:0];
        f.data[0] = pci;
        for (i = 1; i < 8; i++)
            f.data[i] = 8'($urandom_range(0, 255));
        return f;
    endfunction

    function automatic frame_t make_first(input int dlc, input int count);
        frame_t f;
        f         = make_frame(dlc, {TYPE_FF, count[11:8]});
        f.data[1] = count[7:0];
        return f;
    endfunction

    function automatic frame_t noise_frame();
        logic [7:0] pci;
        int         dlc;
        pci = 8'($urandom_range(0, 255));
        dlc = $urandom_range(0, 15);
        case ($urandom_range(0, 3))
            0: dlc = 0;
            1: pci[7:4] = 4'($urandom_range(TYPE_FC, TYPE_LAST));
            2:
            begin
                pci[7:4] = TYPE_CF;
                dlc      = 1;
            end
            default: ;
        endcase
        return make_frame(dlc, pci);
    endfunction

    function automatic void queue_result(input kind_t kind, input logic [7:0] data,
                                         input int len, input bit fin);
        result_t r;
        r.kind = kind;
        r.data = data;
        r.len  = len[6:0];
        r.last = fin;
        due_results.push_back(r);
    endfunction

    // Updates the reassembly state and queues the results of one frame.
    // Returns 1 when the frame changed state or produced results.
    function automatic bit reassemble_frame(input frame_t f);
        int dlc;
        int nib;
        int count;
        int i;
        dlc = f.dlc;
        if (dlc > DLC_MAX)
            dlc = DLC_MAX;
        nib = f.data[0][3:0];
        if (dlc == 0)
            return 1'b0;
        case (f.data[0][7:4])
            TYPE_SF:
            begin
                if (nib > SF_MAX || nib > dlc - 1)
                    return 1'b0;
                singles_delivered++;
                if (nib == 0)
                begin
                    queue_result(KIND_EMPTY, 8'h00, 0, 1'b1);
                    return 1'b1;
                end
                for (i = 0; i < nib; i++)
                    queue_result(KIND_BYTE, f.data[1 + i], nib, i == nib - 1);
                return 1'b1;
            end
            TYPE_FF:
            begin
                if (dlc < DLC_MAX)
                    return 1'b0;
                count = {f.data[0][3:0], f.data[1]};
                if (count < FF_MIN_LEN || count > BUF_BYTES)
                    return 1'b0;
                asm_len = count;
                for (i = 0; i < FF_PAYLOAD; i++)
                    asm_buf[i] = f.data[2 + i];
                asm_held   = FF_PAYLOAD;
                asm_seq    = 4'd1;
                asm_active = 1'b1;
                queue_result(KIND_CTS, 8'h00, asm_len, 1'b1);
                return 1'b1;
            end
            TYPE_CF:
            begin
                if (!asm_active || dlc < 2)
                    return 1'b0;
                if (f.data[0][3:0] != asm_seq)
                begin
                    asm_active = 1'b0;
                    return 1'b1;
                end
                count = asm_len - asm_held;
                if (count > CF_MAX)
                    count = CF_MAX;
                if (count > dlc - 1)
                    count = dlc - 1;
                for (i = 0; i < count; i++)
                    asm_buf[asm_held + i] = f.data[1 + i];
                asm_held += count;
                asm_seq  = asm_seq + 4'd1;
                if (asm_held >= asm_len)
                begin
                    for (i = 0; i < asm_len; i++)
                        queue_result(KIND_BYTE, asm_buf[i], asm_len, i == asm_len - 1);
                    asm_active = 1'b0;
                    messages_reassembled++;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_frame(input frame_t f);
        int gap;
        gap = draw_wait(sender_pauses);
        if (gap > 0)
        begin
            frame_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame_len   <= f.dlc;
        frame_byte0 <= f.data[0];
        frame_byte1 <= f.data[1];
        frame_byte2 <= f.data[2];
        frame_byte3 <= f.data[3];
        frame_byte4 <= f.data[4];
        frame_byte5 <= f.data[5];
        frame_byte6 <= f.data[6];
        frame_byte7 <= f.data[7];
        do
            @(posedge clk);
        while (frame_ready !== 1'b1);
        frames_sent++;
        frames_effective += reassemble_frame(f);
    endtask

    task automatic wait_for_results();
        frame_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_results.size() != 0);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic send_random_single();
        int     n;
        frame_t f;
        n = $urandom_range(0, SF_MAX);
        f = make_frame(($urandom_range(0, 4) == 0) ? $urandom_range(9, 15)
                                                   : $urandom_range(n + 1, DLC_MAX),
                       {TYPE_SF, n[3:0]});
        send_frame(f);
    endtask

    // First frame, then consecutive frames until the message completes or drops.
    task automatic send_transfer(input int count, input bit short_cf, input bit noisy);
        frame_t     f;
        int         pick;
        logic [3:0] seq;
        send_frame(make_first(($urandom_range(0, 4) == 0) ? $urandom_range(9, 15)
                                                          : DLC_MAX, count));
        while (asm_active)
        begin
            pick = noisy ? $urandom_range(0, 99) : 99;
            seq  = asm_seq;
            if (pick < 3)
                seq = 4'(seq + $urandom_range(1, 15));
            if (pick >= 3 && pick < 7)
                f = noise_frame();
            else if (pick >= 7 && pick < 9)
                f = make_first(DLC_MAX, $urandom_range(FF_MIN_LEN, 20));
            else
                f = make_frame(short_cf ? $urandom_range(1, 3) : $urandom_range(1, 15),
                               {TYPE_CF, seq});
            send_frame(f);
        end
    endtask

    task automatic test_single_frames();
        frame_t f;
        int     i;
        send_frame(make_frame(1, {TYPE_SF, 4'd0}));
        f = make_frame(15, {TYPE_SF, 4'd7});
        for (i = 1; i < 8; i++)
            f.data[i] = 8'hFF;
        send_frame(f);
        f         = make_frame(2, {TYPE_SF, 4'd1});
        f.data[1] = 8'h00;
        send_frame(f);
        send_frame(make_frame(3, {TYPE_SF, 4'd3}));
        send_frame(make_frame(8, {TYPE_SF, 4'hF}));
        send_frame(make_frame(0, {TYPE_SF, 4'd1}));
        send_frame(make_frame(8, {TYPE_FC, 4'd7}));
        wait_for_results();
    endtask

    task automatic test_first_frames();
        send_frame(make_first(7, 10));
        send_frame(make_first(8, 6));
        send_frame(make_first(8, 65));
        send_frame(make_first(8, 12'hF40));
        send_frame(make_frame(8, {TYPE_CF, 4'd1}));
        send_frame(make_first(8, 7));
        send_frame(make_first(8, BUF_BYTES));
        send_frame(make_frame(8, {TYPE_CF, 4'd2}));
        send_frame(make_frame(8, {TYPE_CF, 4'd1}));
        wait_for_results();
    endtask

    task automatic test_sequence_wrap();
        int i;
        send_frame(make_first(8, 22));
        send_frame(make_frame(1, {TYPE_CF, 4'd1}));
        // one byte per frame so the sequence runs past 15 back to 0
        for (i = 1; i <= 16; i++)
            send_frame(make_frame((i == 16) ? 12 : 2, {TYPE_CF, i[3:0]}));
        wait_for_results();
    endtask

    task automatic test_receiver_hold();
        int i;
        sender_pauses = 1'b0;
        receiver_hold = HOLD_CYCLES;
        send_transfer(BUF_BYTES, 1'b0, 1'b0);
        for (i = 0; i < 4; i++)
            send_random_single();
        wait_for_results();
        sender_pauses = 1'b1;
    endtask

    task automatic test_random_traffic();
        int base;
        int pick;
        int size_pick;
        int count;
        base = frames_effective;
        while (frames_effective - base < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                sender_pauses   = 1'($urandom_range(0, 1));
                receiver_pauses = 1'($urandom_range(0, 1));
            end
            pick      = $urandom_range(0, 19);
            size_pick = $urandom_range(0, 19);
            count     = (size_pick == 0) ? BUF_BYTES :
                        (size_pick < 4)  ? $urandom_range(21, BUF_BYTES - 1) :
                                           $urandom_range(FF_MIN_LEN, 20);
            if (pick < 11)
                send_transfer(count, $urandom_range(0, 3) == 0, 1'b1);
            else if (pick < 16)
                send_random_single();
            else
                send_frame(noise_frame());
        end
        wait_for_results();
    endtask

    initial
    begin : receiver
        int stall;
        result_ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (receiver_hold > 0)
            begin
                result_ready <= 1'b0;
                repeat (receiver_hold) @(posedge clk);
                receiver_hold = 0;
            end
            stall = draw_wait(receiver_pauses);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_valid && result_ready) && receiver_hold == 0);
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_checked++;
            if (due_results.size() == 0)
                report_mismatch("result beat with none due", result_kind, 0);
            else
            begin
                want = due_results.pop_front();
                if (result_kind !== want.kind)
                    report_mismatch("result_kind", result_kind, want.kind);
                if (payload_byte !== want.data)
                    report_mismatch("payload_byte", payload_byte, want.data);
                if (message_length !== want.len)
                    report_mismatch("message_length", message_length, want.len);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
            end
        end
    end

    // longest legal quiet stretch is the receiver hold plus a few stalls
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (frame_valid && frame_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles, %0d results due",
                     QUIET_LIMIT, due_results.size());
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n       <= 1'b0;
        frame_valid <= 1'b0;
        frame_len   <= '0;
        frame_byte0 <= '0;
        frame_byte1 <= '0;
        frame_byte2 <= '0;
        frame_byte3 <= '0;
        frame_byte4 <= '0;
        frame_byte5 <= '0;
        frame_byte6 <= '0;
        frame_byte7 <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_frames();
        test_first_frames();
        test_sequence_wrap();
        test_receiver_hold();
        test_random_traffic();

        $display("%0d frames sent (%0d took effect), %0d result beats checked",
                 frames_sent, frames_effective, results_checked);
        $display("%0d messages reassembled, %0d single frames delivered, %0d mismatches",
                 messages_reassembled, singles_delivered, mismatch_count);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
